@@ sv/bovr_pkg.sv @@
// Shared constants and types for the box overlap volume ratio block.
package bovr_pkg;

    // Default coordinate width and queue depth.
    localparam int COORD_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Fixed result and accumulator widths.
    localparam int SUM_W     = 64;
    localparam int RATIO_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int AXES      = 3;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_X = 3'd0,
        CFG_MIN_Y = 3'd1,
        CFG_MIN_Z = 3'd2,
        CFG_MAX_X = 3'd3,
        CFG_MAX_Y = 3'd4,
        CFG_MAX_Z = 3'd5
    } t_cfg_idx;

    // Divider sequencer states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_VOL  = 5'b00010,
        S_PREP = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_div_state;

    // Request from the accumulator to the divider.
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] sum;
    } t_acc_req;

endpackage

@@ sv/bovr_ifs.sv @@
// Handshake channel interfaces for boxes, results and configuration writes.
interface bovr_box_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] box_min_x;
    logic signed [COORD_BITS-1:0] box_min_y;
    logic signed [COORD_BITS-1:0] box_min_z;
    logic signed [COORD_BITS-1:0] box_max_x;
    logic signed [COORD_BITS-1:0] box_max_y;
    logic signed [COORD_BITS-1:0] box_max_z;
    logic                         last_box;

    modport source (output valid, box_min_x, box_min_y, box_min_z,
                    box_max_x, box_max_y, box_max_z, last_box, input ready);
    modport sink (input valid, box_min_x, box_min_y, box_min_z,
                  box_max_x, box_max_y, box_max_z, last_box, output ready);
endinterface

interface bovr_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] overlap_ratio;
    logic        bad_reference;

    modport source (output valid, overlap_ratio, bad_reference, input ready);
    modport sink (input valid, overlap_ratio, bad_reference, output ready);
endinterface

interface bovr_cfg_if #(parameter int COORD_BITS = 16);
    logic                  valid;
    logic                  ready;
    logic [2:0]            index;
    logic [COORD_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ sv/bovr_fifo.sv @@
// Small register queue between the front and the back part.
module bovr_fifo
    import bovr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and fill count update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ sv/bovr_front.sv @@
// Front part: takes boxes and clamps each axis overlap with the reference box.
module bovr_front
    import bovr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    bovr_box_if.sink                      i_box,
    input  logic signed [COORD_BITS-1:0]  i_ref_min [AXES],
    input  logic signed [COORD_BITS-1:0]  i_ref_max [AXES],
    input  logic                          i_full,
    output logic                          o_push,
    output logic [AXES*COORD_BITS:0]      o_data
);
    logic signed [COORD_BITS-1:0] w_bmin [AXES];
    logic signed [COORD_BITS-1:0] w_bmax [AXES];
    logic signed [COORD_BITS-1:0] w_lo   [AXES];
    logic signed [COORD_BITS-1:0] w_hi   [AXES];
    logic signed [COORD_BITS:0]   w_diff [AXES];
    logic [COORD_BITS-1:0]        w_ov   [AXES];

    assign w_bmin[0] = i_box.box_min_x;
    assign w_bmin[1] = i_box.box_min_y;
    assign w_bmin[2] = i_box.box_min_z;
    assign w_bmax[0] = i_box.box_max_x;
    assign w_bmax[1] = i_box.box_max_y;
    assign w_bmax[2] = i_box.box_max_z;

    // Per-axis overlap, clamped at zero.
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            w_lo[a]   = (i_ref_min[a] > w_bmin[a]) ? i_ref_min[a] : w_bmin[a];
            w_hi[a]   = (i_ref_max[a] < w_bmax[a]) ? i_ref_max[a] : w_bmax[a];
            w_diff[a] = {w_hi[a][COORD_BITS-1], w_hi[a]} - {w_lo[a][COORD_BITS-1], w_lo[a]};
            w_ov[a]   = (w_diff[a] > 0) ? w_diff[a][COORD_BITS-1:0] : '0;
        end
    end

    // An item enters the queue whenever the queue has room.
    assign i_box.ready = !i_full;
    assign o_push      = i_box.valid && !i_full;
    assign o_data      = {i_box.last_box, w_ov[2], w_ov[1], w_ov[0]};

endmodule

@@ sv/bovr_back.sv @@
// Back part: multiplies the overlaps and keeps the saturating volume sum.
module bovr_back
    import bovr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_empty,
    input  logic [AXES*COORD_BITS:0] i_data,
    output logic                     o_pop,
    input  logic                     i_div_busy,
    output t_acc_req                 o_req
);
    localparam int P1_W   = 2 * COORD_BITS;
    localparam int PROD_W = 3 * COORD_BITS;

    logic [COORD_BITS-1:0] w_ovx;
    logic [COORD_BITS-1:0] w_ovy;
    logic [COORD_BITS-1:0] w_ovz;
    logic                  w_last;
    logic                  w_adv;
    logic [SUM_W:0]        w_add;
    logic [SUM_W-1:0]      w_sat;

    logic                  r_s1_valid;
    logic                  r_s1_last;
    logic [P1_W-1:0]       r_s1_p;
    logic [COORD_BITS-1:0] r_s1_z;
    logic                  r_s2_valid;
    logic                  r_s2_last;
    logic [PROD_W-1:0]     r_s2_p;
    logic [SUM_W-1:0]      r_sum;

    assign w_ovx  = i_data[COORD_BITS-1:0];
    assign w_ovy  = i_data[2*COORD_BITS-1:COORD_BITS];
    assign w_ovz  = i_data[3*COORD_BITS-1:2*COORD_BITS];
    assign w_last = i_data[3*COORD_BITS];

    // The pipe holds only while a finished list waits for the divider.
    assign w_adv = !(r_s2_valid && r_s2_last && i_div_busy);
    assign o_pop = w_adv && !i_empty;

    // Saturating add of the box volume to the running sum.
    assign w_add = {1'b0, r_sum} + (SUM_W + 1)'(r_s2_p);
    assign w_sat = w_add[SUM_W] ? '1 : w_add[SUM_W-1:0];

    assign o_req.start = r_s2_valid && r_s2_last && !i_div_busy;
    assign o_req.sum   = w_sat;

    // Stage valids and the running sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_sum      <= '0;
        end else if (w_adv) begin
            r_s1_valid <= o_pop;
            r_s2_valid <= r_s1_valid;
            if (r_s2_valid) begin
                r_sum <= r_s2_last ? '0 : w_sat;
            end
        end
    end

    // Two multiply stages.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_p    <= P1_W'(w_ovx) * P1_W'(w_ovy);
            r_s1_z    <= w_ovz;
            r_s1_last <= w_last;
            r_s2_p    <= PROD_W'(r_s1_p) * PROD_W'(r_s1_z);
            r_s2_last <= r_s1_last;
        end
    end

endmodule

@@ sv/bovr_div.sv @@
// Reference volume and bit-serial Q16.16 division of the summed volume.
module bovr_div
    import bovr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic signed [COORD_BITS-1:0] i_ref_min [AXES],
    input  logic signed [COORD_BITS-1:0] i_ref_max [AXES],
    input  t_acc_req                     i_req,
    output logic                         o_busy,
    bovr_res_if.source                   o_res
);
    localparam int P1_W  = 2 * COORD_BITS;
    localparam int REM_W = 3 * COORD_BITS;
    localparam int CNT_W = $clog2(RATIO_W);

    logic signed [COORD_BITS:0] w_d   [AXES];
    logic [COORD_BITS-1:0]      w_mag [AXES];
    logic                       w_zero;
    logic                       w_neg;
    logic [REM_W:0]             w_shift;
    logic                       w_ge;

    t_div_state           r_state;
    t_div_state           n_state;
    logic [SUM_W-1:0]     r_num;
    logic [P1_W-1:0]      r_m1;
    logic [REM_W-1:0]     r_den;
    logic [REM_W-1:0]     r_rem;
    logic [RATIO_W-1:0]   r_low;
    logic [RATIO_W-1:0]   r_quo;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_bad;

    // Reference edge lengths: magnitude, zero and sign of the volume.
    always_comb begin
        w_zero = 1'b0;
        w_neg  = 1'b0;
        for (int a = 0; a < AXES; a++) begin
            w_d[a]   = {i_ref_max[a][COORD_BITS-1], i_ref_max[a]}
                     - {i_ref_min[a][COORD_BITS-1], i_ref_min[a]};
            w_mag[a] = w_d[a][COORD_BITS] ? COORD_BITS'(-w_d[a]) : w_d[a][COORD_BITS-1:0];
            w_zero   = w_zero | (w_d[a] == '0);
            w_neg    = w_neg ^ w_d[a][COORD_BITS];
        end
    end

    // One restoring division step.
    assign w_shift = {r_rem, r_low[RATIO_W-1]};
    assign w_ge    = (w_shift >= (REM_W + 1)'(r_den));

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_req.start) n_state = S_VOL;
            S_VOL:  n_state = S_PREP;
            S_PREP: begin
                if (r_bad || ((r_num >> FRAC_BITS) >= SUM_W'(r_den))) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV:  if (r_cnt == '0) n_state = S_OUT;
            S_OUT:  if (o_res.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers. The dividend is the sum shifted left by the
    // fraction width; its upper part seeds the remainder, which is already
    // below the divisor once saturation has been ruled out.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    r_num <= i_req.sum;
                    r_m1  <= P1_W'(w_mag[0]) * P1_W'(w_mag[1]);
                    r_bad <= w_zero || w_neg;
                end
            end
            S_VOL: begin
                r_den <= REM_W'(r_m1) * REM_W'(w_mag[2]);
            end
            S_PREP: begin
                if (r_bad) begin
                    r_quo <= '0;
                end else if ((r_num >> FRAC_BITS) >= SUM_W'(r_den)) begin
                    r_quo <= '1;
                end else begin
                    r_quo <= '0;
                    r_rem <= REM_W'(r_num >> FRAC_BITS);
                    r_low <= {r_num[FRAC_BITS-1:0], {(RATIO_W - FRAC_BITS){1'b0}}};
                    r_cnt <= CNT_W'(RATIO_W - 1);
                end
            end
            S_DIV: begin
                r_rem <= w_ge ? REM_W'(w_shift - (REM_W + 1)'(r_den)) : REM_W'(w_shift);
                r_low <= {r_low[RATIO_W-2:0], 1'b0};
                r_quo <= {r_quo[RATIO_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_busy              = (r_state != S_IDLE);
    assign o_res.valid         = (r_state == S_OUT);
    assign o_res.overlap_ratio = r_quo;
    assign o_res.bad_reference = r_bad;

    // A new list only starts on an idle divider.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> r_state == S_IDLE)
        else $error("divider started while busy");

    // The volume product follows a start directly.
    a_start_vol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_state == S_VOL)
        else $error("start did not lead to the volume step");

    // The partial remainder stays below the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < r_den)
        else $error("remainder not below divisor");

    // A bad reference always reports a zero ratio.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.bad_reference) |-> o_res.overlap_ratio == '0)
        else $error("bad reference with nonzero ratio");

endmodule

@@ sv/box_overlap_volume_ratio_unit.sv @@
// Top level of the box overlap volume ratio block.
//
//  Channel  Dir  Payload
//  i_cfg    in   index (3), data (COORD_BITS): reference box corners
//  i_box    in   box_min_x/y/z, box_max_x/y/z (COORD_BITS, signed), last_box
//  o_res    out  overlap_ratio (32, Q16.16), bad_reference
//
// Boxes are taken one per cycle while the queue has room; each box passes
// through two multiply stages into the running sum.
// A list ends on last_box: the divider then forms the reference volume and checks
// in S_IDLE, S_VOL and S_PREP, and one quotient bit per cycle in S_DIV, before the result;
// a bad reference or a saturated ratio skips the quotient steps in S_DIV.
// Boxes of the next list keep flowing until the next last box meets a busy divider.
// Reset is synchronous; it clears the sum, the queue and the control state.
// The result waits in its register until taken; configuration writes are always ready.
module box_overlap_volume_ratio_unit
    import bovr_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bovr_cfg_if.sink   i_cfg,
    bovr_box_if.sink   i_box,
    bovr_res_if.source o_res
);
    localparam int Q_W = AXES * COORD_BITS + 1;

    logic signed [COORD_BITS-1:0] r_ref_min [AXES];
    logic signed [COORD_BITS-1:0] r_ref_max [AXES];

    logic           w_push;
    logic [Q_W-1:0] w_push_data;
    logic           w_full;
    logic           w_pop;
    logic [Q_W-1:0] w_pop_data;
    logic           w_empty;
    logic           w_div_busy;
    t_acc_req       w_req;

    // Configuration register writes.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_ref_min[a] <= '0;
                r_ref_max[a] <= '0;
            end
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_MIN_X: r_ref_min[0] <= i_cfg.data;
                CFG_MIN_Y: r_ref_min[1] <= i_cfg.data;
                CFG_MIN_Z: r_ref_min[2] <= i_cfg.data;
                CFG_MAX_X: r_ref_max[0] <= i_cfg.data;
                CFG_MAX_Y: r_ref_max[1] <= i_cfg.data;
                CFG_MAX_Z: r_ref_max[2] <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    bovr_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_box     (i_box),
        .i_ref_min (r_ref_min),
        .i_ref_max (r_ref_max),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_data    (w_push_data)
    );

    bovr_fifo #(.WIDTH(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_pop_data),
        .o_empty (w_empty)
    );

    bovr_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_empty),
        .i_data     (w_pop_data),
        .o_pop      (w_pop),
        .i_div_busy (w_div_busy),
        .o_req      (w_req)
    );

    bovr_div #(.COORD_BITS(COORD_BITS)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ref_min (r_ref_min),
        .i_ref_max (r_ref_max),
        .i_req     (w_req),
        .o_busy    (w_div_busy),
        .o_res     (o_res)
    );

endmodule

@@ tb/bovr_ratio_checker.sv @@
// Checker that predicts the overlap ratio of every box list and compares it with the block.
`timescale 1ns / 100ps
module bovr_ratio_checker
    import bovr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    bovr_cfg_if  cfg_ch,
    bovr_box_if  box_ch,
    bovr_res_if  res_ch,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_result_count,
    output int   o_bad_count
);

    localparam int CW = 16;

    // One predicted or observed result item.
    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic               bad;
    } t_ratio;

    // Own copy of the reference box and of the running intersection sum.
    logic signed [CW-1:0] ref_lo [AXES];
    logic signed [CW-1:0] ref_hi [AXES];
    logic [SUM_W-1:0]     overlap_sum;
    t_ratio               expected_ratios [$];
    int                   fail_count;
    int                   result_count;
    int                   bad_count;

    // Product of the three axis overlaps of one box with the reference box, each clamped at zero.
    function automatic logic [SUM_W-1:0] overlap_volume(input logic signed [CW-1:0] blo [AXES],
                                                       input logic signed [CW-1:0] bhi [AXES]);
        logic signed [CW:0] lo;
        logic signed [CW:0] hi;
        logic [SUM_W-1:0]   vol;
        vol = 1;
        for (int a = 0; a < AXES; a++) begin
            lo = (ref_lo[a] > blo[a]) ? ref_lo[a] : blo[a];
            hi = (ref_hi[a] < bhi[a]) ? ref_hi[a] : bhi[a];
            if (hi > lo)
                vol = vol * SUM_W'(hi - lo);
            else
                vol = '0;
        end
        return vol;
    endfunction

    // Sum over reference volume in Q16.16, or the bad reference flag.
    function automatic t_ratio volume_ratio(input logic [SUM_W-1:0] sum);
        logic signed [CW:0]         lo_e;
        logic signed [CW:0]         hi_e;
        logic signed [CW:0]         ext;
        logic [SUM_W-1:0]           ref_vol;
        logic [SUM_W+FRAC_BITS-1:0] quot;
        logic                       neg;
        logic                       zero;
        t_ratio                     outcome;
        ref_vol = 1;
        neg     = 1'b0;
        zero    = 1'b0;
        for (int a = 0; a < AXES; a++) begin
            lo_e = ref_lo[a];
            hi_e = ref_hi[a];
            ext  = hi_e - lo_e;
            if (ext == 0) begin
                zero = 1'b1;
            end else if (ext < 0) begin
                neg     = ~neg;
                ref_vol = ref_vol * SUM_W'(-ext);
            end else begin
                ref_vol = ref_vol * SUM_W'(ext);
            end
        end
        if (zero || neg) begin
            outcome.ratio = '0;
            outcome.bad   = 1'b1;
        end else begin
            quot = {sum, {FRAC_BITS{1'b0}}} / (SUM_W + FRAC_BITS)'(ref_vol);
            // An integer part of 65536 or more saturates the ratio.
            if (quot[SUM_W+FRAC_BITS-1:RATIO_W] != '0)
                outcome.ratio = '1;
            else
                outcome.ratio = quot[RATIO_W-1:0];
            outcome.bad = 1'b0;
        end
        return outcome;
    endfunction

    // Watch all three channels at each rising edge.
    always @(posedge i_clk) begin
        logic signed [CW-1:0] blo [AXES];
        logic signed [CW-1:0] bhi [AXES];
        logic [SUM_W:0]       acc;
        t_ratio               got;
        t_ratio               want;
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                ref_lo[a] = '0;
                ref_hi[a] = '0;
            end
            overlap_sum = '0;
            expected_ratios.delete();
        end else begin
            // Register writes update the reference box.
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (t_cfg_idx'(cfg_ch.index))
                    CFG_MIN_X: ref_lo[0] = cfg_ch.data;
                    CFG_MIN_Y: ref_lo[1] = cfg_ch.data;
                    CFG_MIN_Z: ref_lo[2] = cfg_ch.data;
                    CFG_MAX_X: ref_hi[0] = cfg_ch.data;
                    CFG_MAX_Y: ref_hi[1] = cfg_ch.data;
                    CFG_MAX_Z: ref_hi[2] = cfg_ch.data;
                    default: ;
                endcase
            end

            // Each result item is compared with the oldest prediction.
            if (res_ch.valid && res_ch.ready) begin
                got.ratio = res_ch.overlap_ratio;
                got.bad   = res_ch.bad_reference;
                result_count++;
                if (got.bad)
                    bad_count++;
                if (expected_ratios.size() == 0) begin
                    $display("%0t: result with none expected, got ratio %h bad %b",
                             $time, got.ratio, got.bad);
                    fail_count++;
                end else begin
                    want = expected_ratios.pop_front();
                    if (got.ratio !== want.ratio) begin
                        $display("%0t: overlap_ratio expected %h, got %h",
                                 $time, want.ratio, got.ratio);
                        fail_count++;
                    end
                    if (got.bad !== want.bad) begin
                        $display("%0t: bad_reference expected %b, got %b",
                                 $time, want.bad, got.bad);
                        fail_count++;
                    end
                end
            end

            // Each accepted box adds to the sum; the last box of a list closes it.
            if (box_ch.valid && box_ch.ready) begin
                blo[0] = box_ch.box_min_x;
                blo[1] = box_ch.box_min_y;
                blo[2] = box_ch.box_min_z;
                bhi[0] = box_ch.box_max_x;
                bhi[1] = box_ch.box_max_y;
                bhi[2] = box_ch.box_max_z;
                acc = {1'b0, overlap_sum} + {1'b0, overlap_volume(blo, bhi)};
                overlap_sum = acc[SUM_W] ? '1 : acc[SUM_W-1:0];
                if (box_ch.last_box) begin
                    expected_ratios.insert(expected_ratios.size(), volume_ratio(overlap_sum));
                    overlap_sum = '0;
                end
            end
        end
        o_pending      <= expected_ratios.size();
        o_fail_count   <= fail_count;
        o_result_count <= result_count;
        o_bad_count    <= bad_count;
    end

endmodule

@@ tb/tb_box_overlap_volume_ratio_unit.sv @@
// Testbench top that drives reference boxes and box lists into the overlap ratio block.
`timescale 1ns / 100ps
module tb_box_overlap_volume_ratio_unit
    import bovr_pkg::*;
();

    localparam int CW           = 16;
    localparam int CMAX         = 2 ** (CW - 1) - 1;
    localparam int CMIN         = -(2 ** (CW - 1));
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int LONG_LIST    = 40;

    logic i_clk;
    logic i_rst_n;

    bovr_cfg_if #(.COORD_BITS(CW)) cfg_ch ();
    bovr_box_if #(.COORD_BITS(CW)) box_ch ();
    bovr_res_if                    res_ch ();

    int fail_count;
    int pending;
    int result_count;
    int bad_count;
    int send_idle_pct;
    int recv_stall_pct;
    int boxes_sent;
    int lists_sent;
    int cycle_count;

    // Reference box currently loaded, used to aim random boxes at it.
    logic signed [CW-1:0] cur_lo [AXES];
    logic signed [CW-1:0] cur_hi [AXES];

    box_overlap_volume_ratio_unit #(
        .COORD_BITS(CW)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_box   (box_ch),
        .o_res   (res_ch)
    );

    bovr_ratio_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .cfg_ch         (cfg_ch),
        .box_ch         (box_ch),
        .res_ch         (res_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_bad_count    (bad_count)
    );

    // 100 MHz clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Guard against a hung block.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // The result receiver stalls at random.
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_ch.ready <= (32'($urandom_range(99)) >= recv_stall_pct);
        end
    end

    function automatic logic signed [CW-1:0] clamp_coord(input int v);
        if (v > CMAX)
            return CW'(CMAX);
        if (v < CMIN)
            return CW'(CMIN);
        return CW'(v);
    endfunction

    // Wait until every predicted result has come out and the pipeline is empty.
    task automatic wait_idle();
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= CW'(value);
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
    endtask

    // Load a new reference box once the block has gone idle.
    task automatic set_reference(input int lx, input int ly, input int lz,
                                 input int hx, input int hy, input int hz);
        box_ch.valid <= 1'b0;
        wait_idle();
        write_reg(CFG_MIN_X, lx);
        write_reg(CFG_MIN_Y, ly);
        write_reg(CFG_MIN_Z, lz);
        write_reg(CFG_MAX_X, hx);
        write_reg(CFG_MAX_Y, hy);
        write_reg(CFG_MAX_Z, hz);
        cfg_ch.valid <= 1'b0;
        cur_lo[0] = clamp_coord(lx);
        cur_lo[1] = clamp_coord(ly);
        cur_lo[2] = clamp_coord(lz);
        cur_hi[0] = clamp_coord(hx);
        cur_hi[1] = clamp_coord(hy);
        cur_hi[2] = clamp_coord(hz);
    endtask

    // Offer one box item, idling first at random, and wait for it to be taken.
    task automatic send_box(input logic signed [CW-1:0] lo [AXES],
                            input logic signed [CW-1:0] hi [AXES], input logic last);
        while (32'($urandom_range(99)) < send_idle_pct) begin
            box_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        box_ch.valid     <= 1'b1;
        box_ch.box_min_x <= lo[0];
        box_ch.box_min_y <= lo[1];
        box_ch.box_min_z <= lo[2];
        box_ch.box_max_x <= hi[0];
        box_ch.box_max_y <= hi[1];
        box_ch.box_max_z <= hi[2];
        box_ch.last_box  <= last;
        @(posedge i_clk);
        while (!box_ch.ready)
            @(posedge i_clk);
        boxes_sent++;
        if (last)
            lists_sent++;
    endtask

    task automatic send_coords(input int lx, input int ly, input int lz,
                               input int hx, input int hy, input int hz, input logic last);
        logic signed [CW-1:0] lo [AXES];
        logic signed [CW-1:0] hi [AXES];
        lo[0] = clamp_coord(lx);
        lo[1] = clamp_coord(ly);
        lo[2] = clamp_coord(lz);
        hi[0] = clamp_coord(hx);
        hi[1] = clamp_coord(hy);
        hi[2] = clamp_coord(hz);
        send_box(lo, hi, last);
    endtask

    // Mostly boxes placed around the reference box; one in ten is raw noise.
    task automatic send_random_box(input logic last);
        logic signed [CW-1:0] lo [AXES];
        logic signed [CW-1:0] hi [AXES];
        logic                 noise;
        int                   rl;
        int                   rh;
        int                   span;
        int                   a0;
        int                   b0;
        noise = ($urandom_range(9) == 0);
        for (int a = 0; a < AXES; a++) begin
            if (noise) begin
                lo[a] = CW'($urandom);
                hi[a] = CW'($urandom);
            end else begin
                rl = cur_lo[a];
                rh = cur_hi[a];
                if (rl > rh) begin
                    a0 = rl;
                    rl = rh;
                    rh = a0;
                end
                span  = rh - rl + 1;
                a0    = rl - span / 2 + int'($urandom_range(2 * span));
                b0    = a0 - span / 8 + int'($urandom_range(span + span / 2));
                lo[a] = clamp_coord(a0);
                hi[a] = clamp_coord(b0);
            end
        end
        send_box(lo, hi, last);
    endtask

    // Pick a reference box: moderate boxes mostly, with extremes, slivers and odd shapes.
    task automatic pick_reference();
        int lo_v [AXES];
        int hi_v [AXES];
        int kind;
        int t;
        kind = $urandom_range(9);
        for (int a = 0; a < AXES; a++) begin
            case (kind)
                0: begin
                    lo_v[a] = int'($urandom_range(65535)) + CMIN;
                    hi_v[a] = int'($urandom_range(65535)) + CMIN;
                end
                1: begin
                    lo_v[a] = $urandom_range(1) ? CMIN : -int'($urandom_range(1000));
                    hi_v[a] = $urandom_range(1) ? CMAX : int'($urandom_range(1000)) + 1;
                end
                2: begin
                    lo_v[a] = int'($urandom_range(200)) - 100;
                    hi_v[a] = lo_v[a] + int'($urandom_range(3, 1));
                end
                default: begin
                    lo_v[a] = int'($urandom_range(5000)) - 3000;
                    hi_v[a] = lo_v[a] + int'($urandom_range(2500, 1));
                    if ($urandom_range(7) == 0) begin
                        t       = lo_v[a];
                        lo_v[a] = hi_v[a];
                        hi_v[a] = t;
                    end
                end
            endcase
        end
        set_reference(lo_v[0], lo_v[1], lo_v[2], hi_v[0], hi_v[1], hi_v[2]);
    endtask

    // Random lists of one to eight boxes, each closed by a last box.
    task automatic run_lists(input int n_boxes);
        int sent;
        int len;
        sent = 0;
        while (sent < n_boxes) begin
            len = $urandom_range(8, 1);
            for (int k = 0; k < len; k++)
                send_random_box(k == len - 1);
            sent += len;
        end
    endtask

    // Stimulus and verdict.
    initial begin
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        i_rst_n          <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= CFG_MIN_X;
        cfg_ch.data      <= '0;
        box_ch.valid     <= 1'b0;
        box_ch.box_min_x <= '0;
        box_ch.box_min_y <= '0;
        box_ch.box_min_z <= '0;
        box_ch.box_max_x <= '0;
        box_ch.box_max_y <= '0;
        box_ch.box_max_z <= '0;
        box_ch.last_box  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Ordinary reference box: identical, partial, disjoint, inverted and extreme boxes.
        set_reference(-100, -50, 0, 100, 50, 200);
        send_coords(-100, -50, 0, 100, 50, 200, 1'b1);
        send_coords(0, 0, 100, 300, 300, 300, 1'b0);
        send_coords(500, 500, 500, 600, 600, 600, 1'b0);
        send_coords(100, 50, 200, -100, -50, 0, 1'b0);
        send_coords(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1'b1);
        send_coords(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 1'b1);

        // Reference box spanning the whole coordinate range.
        set_reference(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
        send_coords(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1'b1);
        send_coords(0, 0, 0, 1, 1, 1, 1'b1);
        send_coords(CMIN, CMIN, CMIN, 0, 0, 0, 1'b1);

        // Zero extent on one axis flags a bad reference.
        set_reference(5, 0, 0, 5, 10, 10);
        send_coords(0, 0, 0, 10, 10, 10, 1'b0);
        send_coords(0, 0, 0, 10, 10, 10, 1'b1);

        // One inverted axis gives a negative volume.
        set_reference(10, 0, 0, -10, 10, 10);
        send_coords(-20, -20, -20, 20, 20, 20, 1'b1);

        // Two inverted axes give a positive volume but no overlap.
        set_reference(10, 10, 0, -10, -10, 10);
        send_coords(-20, -20, -20, 20, 20, 20, 1'b1);

        // Three inverted axes give a negative volume again.
        set_reference(10, 10, 10, -10, -10, -10);
        send_coords(-20, -20, -20, 20, 20, 20, 1'b1);

        // Unit reference box: long lists of covering boxes give whole-number ratios.
        set_reference(0, 0, 0, 1, 1, 1);
        for (int k = 0; k < LONG_LIST - 1; k++)
            send_coords(-5, -5, -5, 5, 5, 5, k == LONG_LIST - 2);
        for (int k = 0; k < LONG_LIST; k++)
            send_coords(-5, -5, -5, 5, 5, 5, k == LONG_LIST - 1);

        // Random lists under four idling patterns, two reference boxes each.
        for (int mode = 0; mode < 4; mode++) begin
            for (int seg = 0; seg < 2; seg++) begin
                pick_reference();
                case (mode)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                    default: begin send_idle_pct = 35; recv_stall_pct = 35; end
                endcase
                run_lists(185);
            end
        end

        box_ch.valid <= 1'b0;
        wait_idle();

        $display("Sent %0d boxes in %0d lists across directed, long-list and random phases.",
                 boxes_sent, lists_sent);
        $display("Checked %0d ratio items, %0d of them with a bad reference volume.",
                 result_count, bad_count);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
sv/bovr_pkg.sv
sv/bovr_ifs.sv
sv/bovr_fifo.sv
sv/bovr_front.sv
sv/bovr_back.sv
sv/bovr_div.sv
sv/box_overlap_volume_ratio_unit.sv
tb/bovr_ratio_checker.sv
tb/tb_box_overlap_volume_ratio_unit.sv
